### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The condition must never be seen.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

### hw/rtl/hsw_pkg.sv
// ----------------------------------------------------------------------------
// hsw_pkg
// Field widths, register indexes, operation codes and fixed constants.
// ----------------------------------------------------------------------------
package hsw_pkg;

  localparam int OP_W       = 2;
  localparam int IDX_W      = 10;
  localparam int SAMPLE_W   = 24;
  localparam int HARM_W     = 10;
  localparam int AMP_W      = 18;
  localparam int TS_W       = 11;
  localparam int TURN_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int ROM_W      = 16;
  localparam int MAG_W      = 17;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_PER_INDEX = 1'd1;

  localparam logic [TS_W-1:0]   TABLE_SIZE_RESET     = 11'd1024;
  localparam logic [TURN_W-1:0] TURN_PER_INDEX_RESET = 32'd4194304;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  localparam logic [MAG_W-1:0] SINE_ONE = 17'h10000;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [MAG_W-1:0] mag_t;

endpackage

### hw/rtl/hsw_ram.sv
// ----------------------------------------------------------------------------
// hsw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hsw_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/hsw_rem.sv
// ----------------------------------------------------------------------------
// hsw_rem
// Restoring remainder unit: reduces the harmonic number modulo the table size,
// one numerator bit per cycle.
// ----------------------------------------------------------------------------
module hsw_rem #(
  parameter int DEN_W = 11
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [hsw_pkg::HARM_W-1:0] numer,
  input  logic [DEN_W-1:0]          denom,
  output logic                      done,
  output logic [DEN_W-1:0]          rem
);
  import hsw_pkg::*;

  localparam int CW = $clog2(HARM_W + 1);

  logic [CW-1:0]     cnt;
  logic [HARM_W-1:0] num;
  logic [DEN_W-1:0]  den;
  logic [DEN_W:0]    shifted;
  logic [DEN_W:0]    trial;
  logic [DEN_W-1:0]  rem_next;

  assign shifted  = {rem, num[HARM_W-1]};
  assign trial    = shifted - {1'b0, den};
  assign rem_next = (shifted >= {1'b0, den}) ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(HARM_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= numer;
      den <= denom;
      rem <= '0;
    end else if (cnt != '0) begin
      num <= num << 1;
      rem <= rem_next;
    end
  end

endmodule

### hw/rtl/hsw_sine.sv
// ----------------------------------------------------------------------------
// hsw_sine
// Quarter-wave sine lookup: folds a 32-bit turn fraction into the first
// quadrant, scales it to a table index and reads the magnitude. Two stages.
// ----------------------------------------------------------------------------
module hsw_sine #(
  parameter int DEPTH = 256
) (
  input  logic                      clk,
  input  logic [hsw_pkg::TURN_W-1:0] angle,
  output logic [hsw_pkg::MAG_W-1:0]  mag,
  output logic                      neg
);
  import hsw_pkg::*;

  localparam int IW    = $clog2(DEPTH + 1);
  localparam int RW    = $clog2(DEPTH);
  localparam int MUL_W = 31 + IW;

  logic [ROM_W-1:0] rom_tbl [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_rom
    localparam logic [63:0] X   = (64'(k) * HALF_PI_Q30) / DEPTH;
    localparam logic [63:0] X2  = (X * X) >> 30;
    localparam logic [63:0] T1  = ((X * X2) >> 30) / 6;
    localparam logic [63:0] T2  = ((T1 * X2) >> 30) / 20;
    localparam logic [63:0] T3  = ((T2 * X2) >> 30) / 42;
    localparam logic [63:0] T4  = ((T3 * X2) >> 30) / 72;
    localparam logic [63:0] T5  = ((T4 * X2) >> 30) / 110;
    localparam logic [63:0] T6  = ((T5 * X2) >> 30) / 156;
    localparam logic [63:0] POS = X + T2 + T4 + T6;
    localparam logic [63:0] NEG = T1 + T3 + T5;
    localparam logic [63:0] SC  = (POS > NEG) ? (POS - NEG) : 64'd0;
    localparam logic [63:0] R   = (SC * 64'd65536 + 64'd536870912) >> 30;
    localparam logic [ROM_W-1:0] V = (R > 64'd65535) ? 16'hFFFF : R[ROM_W-1:0];
    assign rom_tbl[k] = V;
  end

  logic [30:0]      folded;
  logic [MUL_W-1:0] scaled;
  logic [IW-1:0]    idx;
  logic             neg_a;

  assign folded = angle[30] ? (31'h40000000 - {1'b0, angle[29:0]}) : {1'b0, angle[29:0]};
  assign scaled = MUL_W'(folded) * MUL_W'(DEPTH);

  always_ff @(posedge clk) begin
    idx   <= scaled[30 +: IW];
    neg_a <= angle[31];
    mag   <= (idx == IW'(DEPTH)) ? SINE_ONE : {1'b0, rom_tbl[idx[RW-1:0]]};
    neg   <= neg_a;
  end

endmodule

### hw/rtl/harmonic_sum_wavetable.sv
// ----------------------------------------------------------------------------
// harmonic_sum_wavetable
// Wavetable of signed Q4.19 samples built by additive synthesis.
//
// A command transfer happens on a rising edge with start high and busy low.
// Operation write stores sample_value at index, read returns the entry at
// index, and add sums amplitude * sin(phase) into every entry in use, with
// the phase stepping by harmonic modulo table_size. Each command gives one
// result transfer: done is high for exactly one cycle with read_value and
// clipped, and the receiver cannot hold it off.
// Write, unknown codes and an add with a table size of zero answer from idle,
// a read from S_READ. Any other add reduces the harmonic in the remainder unit,
// then streams one table entry per cycle through the read, sine, multiply and
// write-back pipeline of the table RAM, then drains it. Busy is low again in
// the cycle in which done is high, so the next command can be accepted at the
// edge that ends it. Configuration writes go through cfg_write, cfg_index and
// cfg_data; the user must make them only while the block is idle, which the
// block does not enforce. Reset clears control state and restores register
// defaults; table contents are undefined until written.
// ----------------------------------------------------------------------------
module harmonic_sum_wavetable #(
  parameter int TABLE_DEPTH        = 1024,
  parameter int SINE_QUARTER_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  output logic                                done,
  input  logic [hsw_pkg::OP_W-1:0]            operation,
  input  logic [hsw_pkg::IDX_W-1:0]           index,
  input  logic signed [hsw_pkg::SAMPLE_W-1:0] sample_value,
  input  logic [hsw_pkg::HARM_W-1:0]          harmonic,
  input  logic signed [hsw_pkg::AMP_W-1:0]    amplitude,
  output logic signed [hsw_pkg::SAMPLE_W-1:0] read_value,
  output logic                                clipped,
  input  logic                                cfg_write,
  input  logic [hsw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hsw_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import hsw_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int TSC_W  = (CNT_W > TS_W) ? CNT_W : TS_W;
  localparam int IXC_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int ANG_W  = ADDR_W + TURN_W;
  localparam int PR_W   = MAG_W + AMP_W;
  localparam int SUM_W  = SAMPLE_W + 2;

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(SAMPLE_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(SAMPLE_MIN);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_REM   = 5'b00100,
    S_WALK  = 5'b01000,
    S_DRAIN = 5'b10000
  } state_t;

  state_t state;

  logic [TS_W-1:0]   table_size;
  logic [TURN_W-1:0] turn_per_index;

  logic [TSC_W-1:0]  ts_wide;
  logic [CNT_W-1:0]  ts;
  logic              accept;
  logic              idx_ok;
  logic [ADDR_W-1:0] table_addr;
  logic [AMP_W-1:0]  amp_bits;
  logic [AMP_W-1:0]  amp_abs;

  logic [AMP_W-1:0]  amag;
  logic              aneg;
  logic              rd_ok;
  logic [CNT_W-1:0]  step;
  logic [CNT_W-1:0]  n_cnt;
  logic [CNT_W-1:0]  n_cnt_next;
  logic [ADDR_W-1:0] phase;
  logic [ADDR_W-1:0] phase_next;
  logic [CNT_W:0]    phase_sum;
  logic [ANG_W-1:0]  angle_full;
  logic              clip_acc;

  logic              rem_start;
  logic              rem_done;
  logic [CNT_W-1:0]  rem_val;

  logic              v1, v2, v3, v4;
  logic [ADDR_W-1:0] a1, a2, a3, a4;
  logic [TURN_W-1:0] angle1;
  sample_t           old2, old3, old4;
  logic [SAMPLE_W-1:0] prod4;
  logic              flip4;

  mag_t              sin_mag;
  logic              sin_neg;
  logic [PR_W-1:0]   prod_full;

  logic signed [SUM_W-1:0] ext_old;
  logic signed [SUM_W-1:0] ext_prod;
  logic signed [SUM_W-1:0] sum_wide;
  sample_t           sum_sat;
  logic              clip_now;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size     <= TABLE_SIZE_RESET;
      turn_per_index <= TURN_PER_INDEX_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TABLE_SIZE:     table_size     <= cfg_data[TS_W-1:0];
        REG_TURN_PER_INDEX: turn_per_index <= cfg_data;
      endcase
    end
  end

  assign ts_wide    = (TSC_W'(table_size) > TSC_W'(TABLE_DEPTH)) ? TSC_W'(TABLE_DEPTH)
                                                                 : TSC_W'(table_size);
  assign ts         = ts_wide[CNT_W-1:0];
  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign idx_ok     = IXC_W'(index) < IXC_W'(TABLE_DEPTH);
  assign table_addr = ADDR_W'(index);
  assign amp_bits   = amplitude;
  assign amp_abs    = amp_bits[AMP_W-1] ? (~amp_bits + 1'b1) : amp_bits;
  assign rem_start  = accept && (operation == OP_ADD) && (ts != '0);

  assign n_cnt_next = n_cnt + 1'b1;
  assign phase_sum  = (CNT_W+1)'(phase) + (CNT_W+1)'(step);
  assign phase_next = (phase_sum >= (CNT_W+1)'(ts)) ? ADDR_W'(phase_sum - (CNT_W+1)'(ts))
                                                    : ADDR_W'(phase_sum);
  assign angle_full = ANG_W'(phase) * ANG_W'(turn_per_index);

  assign prod_full = PR_W'(amag) * PR_W'(sin_mag) + PR_W'(1024);

  assign ext_old  = SUM_W'(old4);
  assign ext_prod = $signed({2'b00, prod4});
  assign sum_wide = flip4 ? (ext_old - ext_prod) : (ext_old + ext_prod);

  always_comb begin
    clip_now = 1'b0;
    sum_sat  = sum_wide[SAMPLE_W-1:0];
    if (sum_wide > SUM_MAX) begin
      sum_sat  = SAMPLE_MAX;
      clip_now = 1'b1;
    end else if (sum_wide < SUM_MIN) begin
      sum_sat  = SAMPLE_MIN;
      clip_now = 1'b1;
    end
  end

  assign ram_we    = v4 || (accept && (operation == OP_WRITE) && idx_ok);
  assign ram_waddr = v4 ? a4 : table_addr;
  assign ram_wdata = v4 ? sum_sat : sample_value;
  assign ram_raddr = (state == S_WALK) ? n_cnt[ADDR_W-1:0] : table_addr;

  hsw_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  hsw_rem #(
    .DEN_W (CNT_W)
  ) u_rem (
    .clk   (clk),
    .rst   (rst),
    .start (rem_start),
    .numer (harmonic),
    .denom (ts),
    .done  (rem_done),
    .rem   (rem_val)
  );

  hsw_sine #(
    .DEPTH (SINE_QUARTER_DEPTH)
  ) u_sine (
    .clk   (clk),
    .angle (angle1),
    .mag   (sin_mag),
    .neg   (sin_neg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      read_value <= '0;
      clipped    <= 1'b0;
      clip_acc   <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      v4         <= 1'b0;
    end else begin
      done <= 1'b0;
      v1   <= 1'b0;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      if (v4) begin
        clip_acc <= clip_acc | clip_now;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (operation)
              OP_ADD: begin
                if (ts == '0) begin
                  done       <= 1'b1;
                  read_value <= '0;
                  clipped    <= 1'b0;
                end else begin
                  state <= S_REM;
                end
              end
              OP_READ: state <= S_READ;
              default: begin
                done       <= 1'b1;
                read_value <= '0;
                clipped    <= 1'b0;
              end
            endcase
          end
        end
        S_READ: begin
          done       <= 1'b1;
          read_value <= rd_ok ? $signed(ram_rdata) : '0;
          clipped    <= 1'b0;
          state      <= S_IDLE;
        end
        S_REM: begin
          if (rem_done) begin
            clip_acc <= 1'b0;
            state    <= S_WALK;
          end
        end
        S_WALK: begin
          v1 <= 1'b1;
          if (n_cnt_next == ts) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (v4 && !v3) begin
            done       <= 1'b1;
            read_value <= '0;
            clipped    <= clip_acc | clip_now;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      amag  <= amp_abs;
      aneg  <= amp_bits[AMP_W-1];
      rd_ok <= idx_ok;
    end
    if (state == S_REM && rem_done) begin
      step  <= rem_val;
      n_cnt <= '0;
      phase <= '0;
    end else if (state == S_WALK) begin
      n_cnt <= n_cnt_next;
      phase <= phase_next;
    end
    a1     <= n_cnt[ADDR_W-1:0];
    angle1 <= angle_full[TURN_W-1:0];
    a2     <= a1;
    old2   <= ram_rdata;
    a3     <= a2;
    old3   <= old2;
    a4     <= a3;
    old4   <= old3;
    prod4  <= prod_full[11 +: SAMPLE_W];
    flip4  <= sin_neg ^ aneg;
  end

`include "assert_macros.svh"

  `ASSERT_NEXT(a_add_goes_busy, accept && operation == OP_ADD && ts != '0, busy, "add not busy")
  `ASSERT_SAME(a_done_when_idle, done, !busy, "result transfer while busy")
  `ASSERT_NEVER(a_no_writeback_idle, v4 && state == S_IDLE, "write-back after add finished")
  `ASSERT_SAME(a_walk_in_range, state == S_WALK, n_cnt < ts, "walk beyond table size")

endmodule

### tb/wavetable_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wavetable_checker
// Watches the command, result and register ports of the harmonic wavetable.
// It keeps its own copy of the table, the sine quarter wave and the two
// registers, predicts the result of every accepted command and compares it
// with the next result transfer.
// ----------------------------------------------------------------------------
module wavetable_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic                                done,
  input  logic [hsw_pkg::OP_W-1:0]            operation,
  input  logic [hsw_pkg::IDX_W-1:0]           index,
  input  hsw_pkg::sample_t                    sample_value,
  input  logic [hsw_pkg::HARM_W-1:0]          harmonic,
  input  logic signed [hsw_pkg::AMP_W-1:0]    amplitude,
  input  hsw_pkg::sample_t                    read_value,
  input  logic                                clipped,
  input  logic                                cfg_write,
  input  logic [hsw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hsw_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                  mismatches,
  output int                                  results_seen,
  output int                                  clip_seen,
  output int                                  pending
);
  import hsw_pkg::*;

  localparam int DEPTH = 1024;
  localparam int QUARTER = 256;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint TOP_LIMIT = 64'sd8388607;
  localparam longint BOTTOM_LIMIT = -64'sd8388608;

  typedef struct packed {
    sample_t value;
    logic    clip;
  } table_result_t;

  sample_t         wave [DEPTH];
  logic [15:0]     quarter_sine [QUARTER];
  logic [TS_W-1:0] size_reg;
  logic [TURN_W-1:0] turn_reg;
  table_result_t   due_results [$];

  initial begin : setup
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint acc;
    // The quarter wave comes from a seven-term Taylor series in Q2.30.
    for (int k = 0; k < QUARTER; k++) begin
      x = (64'(k) * PI_HALF_Q30) / 64'(QUARTER);
      x2 = (x * x) >> 30;
      term = x;
      acc = x;
      for (int n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      r = (64'(acc) * 64'd65536 + (64'd1 << 29)) >> 30;
      quarter_sine[k] = (r > 64'd65535) ? 16'hFFFF : r[15:0];
    end
  end

  function automatic table_result_t table_command_result(
    input logic [OP_W-1:0]       op,
    input logic [IDX_W-1:0]      idx,
    input sample_t               smp,
    input logic [HARM_W-1:0]     harm,
    input logic signed [AMP_W-1:0] amp
  );
    table_result_t   res;
    int              entries;
    int              step;
    int              phase;
    logic [63:0]     wide;
    logic [31:0]     angle;
    logic [30:0]     frac;
    int              slot;
    longint          amp_full;
    longint unsigned amp_mag;
    longint unsigned sine_mag;
    longint unsigned prod_mag;
    longint          delta;
    longint          total;
    res = '0;
    case (op)
      OP_WRITE: begin
        wave[idx] = smp;
      end
      OP_READ: begin
        res.value = wave[idx];
      end
      OP_ADD: begin
        entries = (size_reg > DEPTH) ? DEPTH : int'(size_reg);
        if (entries != 0) begin
          step = int'(harm) % entries;
          amp_full = amp;
          amp_mag = (amp_full < 0) ? 64'(-amp_full) : 64'(amp_full);
          phase = 0;
          for (int n = 0; n < entries; n++) begin
            wide = 64'(phase) * {32'd0, turn_reg};
            angle = wide[31:0];
            frac = {1'b0, angle[29:0]};
            if (angle[30]) begin
              frac = 31'h40000000 - frac;
            end
            slot = int'(frac >> 22);
            sine_mag = (slot >= QUARTER) ? 64'd65536 : 64'(quarter_sine[slot]);
            prod_mag = (amp_mag * sine_mag + 64'd1024) >> 11;
            delta = longint'(prod_mag);
            if (angle[31] != (amp_full < 0)) begin
              delta = -delta;
            end
            total = longint'(wave[n]) + delta;
            if (total > TOP_LIMIT) begin
              total = TOP_LIMIT;
              res.clip = 1'b1;
            end
            if (total < BOTTOM_LIMIT) begin
              total = BOTTOM_LIMIT;
              res.clip = 1'b1;
            end
            wave[n] = total[SAMPLE_W-1:0];
            phase = phase + step;
            if (phase >= entries) begin
              phase = phase - entries;
            end
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    table_result_t want;
    if (rst) begin
      size_reg = TABLE_SIZE_RESET;
      turn_reg = TURN_PER_INDEX_RESET;
      due_results.delete();
    end else begin
      if (done) begin
        if (due_results.size() == 0) begin
          $error("result transfer with no command outstanding: read_value %0d clipped %0b",
                 read_value, clipped);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          results_seen++;
          if (clipped === 1'b1) begin
            clip_seen++;
          end
          if (read_value !== want.value) begin
            $error("read_value mismatch: expected %0d, actual %0d", want.value, read_value);
            mismatches++;
          end
          if (clipped !== want.clip) begin
            $error("clipped mismatch: expected %0b, actual %0b", want.clip, clipped);
            mismatches++;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_TABLE_SIZE:     size_reg = cfg_data[TS_W-1:0];
          REG_TURN_PER_INDEX: turn_reg = cfg_data[TURN_W-1:0];
          default: begin
          end
        endcase
      end
      if (start && !busy) begin
        due_results.push_back(table_command_result(operation, index, sample_value,
                                                   harmonic, amplitude));
      end
    end
    pending = due_results.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Command-level test of the harmonic wavetable. A short directed sequence
// covers sample extremes, every operation, saturation in both directions and
// harmonics that add nothing; then ten register settings, from a table size
// of zero up to 255, each run a random mix of writes, reads,
// harmonic adds and unused codes with random gaps between command transfers.
// ----------------------------------------------------------------------------
module testbench;
  import hsw_pkg::*;

  localparam int DEPTH = 1024;
  localparam int SETTING_COUNT = 10;
  localparam int ITEMS_PER_SETTING = 30;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic signed [AMP_W-1:0] AMP_TOP = 18'sh1FFFF;
  localparam logic signed [AMP_W-1:0] AMP_BOTTOM = 18'sh20000;

  typedef enum int {TURN_MATCHED, TURN_ZERO, TURN_FULL, TURN_RANDOM} turn_kind_t;

  localparam int SIZES [SETTING_COUNT] = '{8, 1, 0, 2, 37, 100, 16, 200, 64, 255};
  localparam turn_kind_t TURN_KINDS [SETTING_COUNT] = '{
    TURN_MATCHED, TURN_ZERO, TURN_RANDOM, TURN_FULL, TURN_MATCHED,
    TURN_FULL, TURN_RANDOM, TURN_MATCHED, TURN_RANDOM, TURN_MATCHED
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  done;
  logic [OP_W-1:0]       operation = '0;
  logic [IDX_W-1:0]      index = '0;
  sample_t               sample_value = '0;
  logic [HARM_W-1:0]     harmonic = '0;
  logic signed [AMP_W-1:0] amplitude = '0;
  sample_t               read_value;
  logic                  clipped;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int results_seen;
  int clip_seen;
  int pending;

  bit written [DEPTH];
  int gap_max = 9;
  int commands_sent = 0;

  always #4 clk = ~clk;

  harmonic_sum_wavetable dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .operation    (operation),
    .index        (index),
    .sample_value (sample_value),
    .harmonic     (harmonic),
    .amplitude    (amplitude),
    .read_value   (read_value),
    .clipped      (clipped),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  wavetable_checker table_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .operation    (operation),
    .index        (index),
    .sample_value (sample_value),
    .harmonic     (harmonic),
    .amplitude    (amplitude),
    .read_value   (read_value),
    .clipped      (clipped),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .results_seen (results_seen),
    .clip_seen    (clip_seen),
    .pending      (pending)
  );

  task automatic issue(
    input logic [OP_W-1:0]       op,
    input logic [IDX_W-1:0]      idx,
    input sample_t               smp,
    input logic [HARM_W-1:0]     harm,
    input logic signed [AMP_W-1:0] amp
  );
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    index <= idx;
    sample_value <= smp;
    harmonic <= harm;
    amplitude <= amp;
    if (op == OP_WRITE) begin
      written[idx] = 1'b1;
    end
    do @(posedge clk); while (busy);
    commands_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    do @(posedge clk); while (busy);
  endtask

  task automatic configure(input logic [TS_W-1:0] size, input logic [TURN_W-1:0] turn);
    logic [CFG_DATA_W-1:0] noise;
    noise = $urandom;
    cfg_write <= 1'b1;
    cfg_index <= REG_TABLE_SIZE;
    cfg_data <= {noise[CFG_DATA_W-1:TS_W], size};
    @(posedge clk);
    cfg_index <= REG_TURN_PER_INDEX;
    cfg_data <= turn;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_commands(input int count, input int entries);
    int                  pick;
    int                  first_open;
    logic [OP_W-1:0]     op;
    logic [IDX_W-1:0]    idx;
    sample_t             smp;
    logic [HARM_W-1:0]   harm;
    logic signed [AMP_W-1:0] amp;
    for (int i = 0; i < count; i++) begin
      if (i % 24 == 0) begin
        gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
      end
      idx = $urandom;
      smp = $urandom;
      harm = $urandom;
      amp = $urandom;
      case ($urandom_range(0, 5))
        0: amp = AMP_TOP;
        1: amp = AMP_BOTTOM;
        default: begin
        end
      endcase
      case ($urandom_range(0, 7))
        0: smp = 24'sh7FFFFF - sample_t'($urandom_range(0, 3));
        1: smp = 24'sh800000 + sample_t'($urandom_range(0, 3));
        default: begin
        end
      endcase
      if ($urandom_range(0, 5) == 0) begin
        harm = (entries == 0) ? '0 : HARM_W'(entries * $urandom_range(0, 1023 / entries));
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        op = OP_UNUSED;
      end else if (pick < 45) begin
        op = OP_WRITE;
      end else if (pick < 75) begin
        op = OP_READ;
        while (!written[idx]) idx++;
      end else begin
        op = OP_ADD;
        first_open = -1;
        for (int n = entries - 1; n >= 0; n--) begin
          if (!written[n]) first_open = n;
        end
        if (first_open >= 0) begin
          op = OP_WRITE;
          idx = IDX_W'(first_open);
        end
      end
      issue(op, idx, smp, harm, amp);
    end
  endtask

  initial begin : stimulus
    int          entries;
    logic [31:0] turn;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Four entries, a quarter turn per index: the sine runs 0, +1, 0, -1.
    configure(11'd4, 32'h40000000);
    issue(OP_WRITE, 10'd0, 24'sh7FFFFF, '0, '0);
    issue(OP_WRITE, 10'd1, 24'sh7FFFFF, '0, '0);
    issue(OP_WRITE, 10'd2, 24'sh000000, '0, '0);
    issue(OP_WRITE, 10'd3, 24'sh800000, '0, '0);
    issue(OP_WRITE, 10'd1023, 24'shFFFFFF, '0, '0);
    issue(OP_READ, 10'd1023, '0, '0, '0);
    issue(OP_UNUSED, 10'h3FF, 24'shFFFFFF, 10'h3FF, 18'sh3FFFF);
    issue(OP_ADD, '0, '0, 10'd1, AMP_TOP);
    issue(OP_READ, 10'd1, '0, '0, '0);
    issue(OP_READ, 10'd3, '0, '0, '0);
    issue(OP_ADD, '0, '0, 10'd1, AMP_BOTTOM);
    issue(OP_ADD, '0, '0, 10'd0, AMP_TOP);
    issue(OP_ADD, '0, '0, 10'd4, AMP_BOTTOM);
    issue(OP_ADD, '0, '0, 10'd1023, '0);
    issue(OP_ADD, '0, '0, 10'd2, -18'sd1);
    issue(OP_ADD, '0, '0, 10'd3, 18'sd1);
    issue(OP_READ, 10'd0, '0, '0, '0);
    issue(OP_READ, 10'd1, '0, '0, '0);
    issue(OP_READ, 10'd2, '0, '0, '0);
    issue(OP_READ, 10'd3, '0, '0, '0);

    for (int p = 0; p < SETTING_COUNT; p++) begin
      drain();
      case (TURN_KINDS[p])
        TURN_MATCHED: turn = 32'(((64'd1 << 32) + 64'(SIZES[p] / 2)) / 64'(SIZES[p]));
        TURN_ZERO:    turn = 32'd0;
        TURN_FULL:    turn = 32'hFFFFFFFF;
        default:      turn = $urandom;
      endcase
      configure(TS_W'(SIZES[p]), turn);
      entries = (SIZES[p] > DEPTH) ? DEPTH : SIZES[p];
      gap_max = 9;
      for (int n = 0; n < entries; n++) begin
        if (!written[n]) begin
          issue(OP_WRITE, IDX_W'(n), sample_t'($urandom), HARM_W'($urandom),
                AMP_W'($urandom));
        end
      end
      random_commands(ITEMS_PER_SETTING, entries);
    end

    drain();
    repeat (40) @(posedge clk);
    $display("summary: %0d commands over %0d register settings, table sizes 0 to 255",
             commands_sent, SETTING_COUNT + 1);
    $display("summary: %0d results checked, %0d of them saturated, %0d mismatches",
             results_seen, clip_seen, mismatches);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/hsw_pkg.sv
hw/rtl/hsw_ram.sv
hw/rtl/hsw_rem.sv
hw/rtl/hsw_sine.sv
hw/rtl/harmonic_sum_wavetable.sv
tb/wavetable_checker.sv
tb/testbench.sv
